// ----- rtl/pvm_pkg.sv -----
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared types and codes of the PCM voice mixer.
// ----------------------------------------------------------------------------
package pvm_pkg;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_DEFINE = 3'd2,
    ACT_PLAY   = 3'd3,
    ACT_STOP   = 3'd4,
    ACT_PAUSE  = 3'd5,
    ACT_RESUME = 3'd6,
    ACT_NONE   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_VOICE  = 2'd1,
    ST_UNDEFINED = 2'd2
  } status_t;

  localparam int unsigned SOUND_ID_W = 4;
  localparam logic [15:0] MASTER_RESET = 16'd32768;
  localparam logic [1:0]  REG_MASTER = 2'd0;

endpackage

// ----- rtl/pcm_voice_mixer.sv -----
// ----------------------------------------------------------------------------
// pcm_voice_mixer
// Multi-voice PCM sample mixer with shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage: drive an item on action and the payload ports with start high while
// busy is low. Exactly one result follows on sample_out/status/clipped,
// marked by done for one cycle; the receiver cannot stall it.
// Non-tick items are processed in S_EXEC, which registers the result, then
// pass through S_DONE, which raises done.
// A tick walks the voices one at a time through a single sample-memory read
// port and one 16x17 multiplier: each voice gets an address state (S_VADDR)
// and a wait state (S_VMAC); its product is folded in when S_VADDR comes round
// again. After the last voice the final S_VADDR folds in the last product,
// S_SCALE scales by master_volume and S_ROUND rounds and saturates; S_DONE ends.
// The voice walk over the single read port makes ticks the longest items.
// busy stays high from acceptance until the cycle before done; the next item
// can be accepted in the done cycle.
// The user writes master_volume through APB address 0 only while idle; the
// block does not enforce it. Reset (rst, synchronous) frees all voices, marks
// all sounds undefined and sets master_volume to unity, but not sample memory.
// ----------------------------------------------------------------------------
module pcm_voice_mixer
  import pvm_pkg::*;
#(
  parameter int NUM_VOICES   = 8,
  parameter int SAMPLE_DEPTH = 65536,
  parameter int NUM_SOUNDS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [3:0]         sound_id,
  input  logic [15:0]        address,
  input  logic [16:0]        length,
  input  logic signed [15:0] sample_value,
  input  logic               repeat_req,
  input  logic [15:0]        voice_volume,
  output logic               done,
  output logic signed [15:0] sample_out,
  output logic [1:0]         status,
  output logic               clipped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SW = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
  localparam logic [16:0] DEPTH17 = 17'(SAMPLE_DEPTH);
  localparam logic [VW:0] NV = (VW + 1)'(NUM_VOICES);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_VADDR, S_VMAC, S_SCALE, S_ROUND, S_DONE
  } state_t;

  state_t state;

  logic [15:0] master_volume;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MASTER) ? {16'd0, master_volume} : 32'd0;

  // memories
  logic signed [15:0] smem [SAMPLE_DEPTH];
  logic signed [15:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [NUM_SOUNDS-1:0] snd_valid;
  logic [15:0] snd_start [NUM_SOUNDS];
  logic [16:0] snd_len   [NUM_SOUNDS];

  logic [NUM_VOICES-1:0] v_active, v_playing, v_repeat;
  logic [SOUND_ID_W-1:0] v_sound [NUM_VOICES];
  logic [16:0] v_pos [NUM_VOICES];
  logic [15:0] v_vol [NUM_VOICES];

  // latched item
  action_t act;
  logic [3:0]  id;
  logic [15:0] addr_q;
  logic [16:0] len_q;
  logic signed [15:0] samp_q;
  logic rep_q;
  logic [15:0] vol_q;

  logic [VW:0] vi;
  logic [VW-1:0] vix;
  assign vix = vi[VW-1:0];
  logic mac_en;
  // volume is unsigned Q1.15, kept positive with a zero sign bit
  logic signed [16:0] mac_vol_s;
  logic signed [39:0] acc;
  logic signed [57:0] scaled;
  logic signed [33:0] rounded;
  assign rounded = 34'((scaled + 58'sd536870912) >>> 30);

  logic id_ok;
  assign id_ok = ({1'b0, id} < 5'(NUM_SOUNDS));
  logic [SW-1:0] idx;
  assign idx = id[SW-1:0];

  // lowest free voice
  logic free_found;
  logic [VW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (!v_active[v]) begin
        free_found = 1'b1;
        free_idx = VW'(v);
      end
    end
  end

  // current voice's sound
  logic cur_ok;
  logic [SW-1:0] cur_s;
  logic [16:0] cur_pos, cur_len, pos_inc;
  always_comb begin
    cur_s = v_sound[vix][SW-1:0];
    cur_ok = ({1'b0, v_sound[vix]} < 5'(NUM_SOUNDS)) && snd_valid[cur_s];
    cur_len = snd_len[cur_s];
    cur_pos = (v_pos[vix] >= cur_len) ? 17'd0 : v_pos[vix];
    pos_inc = cur_pos + 17'd1;
  end

  logic [15:0] sum_addr;
  assign sum_addr = snd_start[cur_s] + cur_pos[15:0];

  always_ff @(posedge clk) begin
    rd_data <= smem[rd_addr];
    if (state == S_EXEC && act == ACT_WRITE && {1'b0, addr_q} < DEPTH17)
      smem[addr_q[AW-1:0]] <= samp_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      master_volume <= MASTER_RESET;
      snd_valid <= '0;
      v_active <= '0;
      v_playing <= '0;
      mac_en <= 1'b0;
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite && paddr == REG_MASTER)
        master_volume <= pwdata[15:0];
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            act <= action_t'(action);
            id <= sound_id;
            addr_q <= address;
            len_q <= length;
            samp_q <= sample_value;
            rep_q <= repeat_req;
            vol_q <= voice_volume;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          sample_out <= '0;
          status <= ST_OK;
          clipped <= 1'b0;
          acc <= '0;
          vi <= '0;
          mac_en <= 1'b0;
          state <= S_DONE;
          case (act) inside
            ACT_TICK: state <= S_VADDR;
            ACT_DEFINE: begin
              if (id_ok) begin
                snd_valid[idx] <= (len_q != 17'd0);
                snd_start[idx] <= 16'(addr_q[AW-1:0]);
                snd_len[idx] <= (len_q > DEPTH17) ? DEPTH17 : len_q;
              end
            end
            ACT_PLAY: begin
              if (!id_ok || !snd_valid[idx]) status <= ST_UNDEFINED;
              else if (!free_found) status <= ST_NO_VOICE;
              else begin
                v_active[free_idx] <= 1'b1;
                v_playing[free_idx] <= 1'b1;
                v_repeat[free_idx] <= rep_q;
                v_sound[free_idx] <= id;
                v_pos[free_idx] <= '0;
                v_vol[free_idx] <= vol_q;
              end
            end
            ACT_STOP, ACT_PAUSE, ACT_RESUME: begin
              for (int v = 0; v < NUM_VOICES; v++) begin
                if (id_ok && v_active[v] && v_sound[v] == id) begin
                  if (act == ACT_STOP) v_active[v] <= 1'b0;
                  else v_playing[v] <= (act == ACT_RESUME);
                end
              end
            end
            default: ;
          endcase
        end
        S_VADDR: begin
          // fold in the previous voice's product while addressing this one
          if (mac_en) acc <= acc + 40'(rd_data * mac_vol_s);
          mac_en <= 1'b0;
          if (vi == NV) begin
            state <= S_SCALE;
          end else begin
            if (v_active[vix] && v_playing[vix]) begin
              if (!cur_ok) v_active[vix] <= 1'b0;
              else begin
                rd_addr <= sum_addr[AW-1:0];
                mac_en <= 1'b1;
                mac_vol_s <= $signed({1'b0, v_vol[vix]});
                if (pos_inc >= cur_len) begin
                  v_pos[vix] <= '0;
                  if (!v_repeat[vix]) v_active[vix] <= 1'b0;
                end else v_pos[vix] <= pos_inc;
              end
            end
            state <= S_VMAC;
          end
        end
        S_VMAC: begin
          vi <= vi + 1'b1;
          state <= S_VADDR;
        end
        S_SCALE: begin
          scaled <= 58'(acc) * $signed({1'b0, master_volume});
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (rounded > 34'sd32767) begin
            sample_out <= 16'sd32767; clipped <= 1'b1;
          end else if (rounded < -34'sd32768) begin
            sample_out <= -16'sd32768; clipped <= 1'b1;
          end else sample_out <= rounded[15:0];
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pcm_voice_mixer_checker.sv -----
// ----------------------------------------------------------------------------
// pcm_voice_mixer_checker
// Port-level checks of the mixer's command handshake and result codes.
// ----------------------------------------------------------------------------
module pcm_voice_mixer_checker
  import pvm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic        clipped,
  input logic        pready
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // a new item may be accepted in the result cycle itself
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result longer than one cycle");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= ST_UNDEFINED) && !(clipped && status != ST_OK))
    else $error("bad result code");

  a_pready: assert property (@(posedge clk) pready) else $error("pready low");

endmodule

bind pcm_voice_mixer pcm_voice_mixer_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .clipped(clipped), .pready(pready)
);
